[design/stfe_pkg.sv]
// ----------------------------------------------------------------------------
// stfe_pkg
// Shared widths, request and register codes and reset values for the
// scrolling text frame engine.
// ----------------------------------------------------------------------------
package stfe_pkg;

	// parameter defaults
	localparam int MSG_DEPTH_DEF  = 64;
	localparam int HL_SLOTS_DEF   = 4;
	localparam int MAX_DISP_DEF   = 16;

	// fixed field widths
	localparam int REQ_W    = 3;
	localparam int TIME_W   = 32;
	localparam int IDX_W    = 6;
	localparam int CHAR_W   = 8;
	localparam int LEVEL_W  = 8;
	localparam int POS_W    = 11;
	localparam int SCROLL_W = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// request codes
	localparam logic [REQ_W-1:0] REQ_TICK       = 3'd0;
	localparam logic [REQ_W-1:0] REQ_WRITE      = 3'd1;
	localparam logic [REQ_W-1:0] REQ_HL_ADD     = 3'd2;
	localparam logic [REQ_W-1:0] REQ_HL_CLR     = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SCROLL_RST = 3'd4;

	// scroll styles
	localparam logic [1:0] STYLE_SMOOTH = 2'd0;
	localparam logic [1:0] STYLE_CHAR   = 2'd1;
	localparam logic [1:0] STYLE_STATIC = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_CHARS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHAR_WIDTH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHAR_SPACING  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_STYLE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LEVEL = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FONT_MODERN   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_MSG_LENGTH    = 3'd7;

	// register reset values
	localparam logic [4:0]  RST_DISPLAY_CHARS = 5'd8;
	localparam logic [3:0]  RST_CHAR_WIDTH    = 4'd5;
	localparam logic [2:0]  RST_CHAR_SPACING  = 3'd1;
	localparam logic [1:0]  RST_SCROLL_STYLE  = STYLE_SMOOTH;
	localparam logic [15:0] RST_PERIOD_MS     = 16'd50;
	localparam logic [7:0]  RST_DEFAULT_LEVEL = 8'd1;
	localparam logic        RST_FONT_MODERN   = 1'b1;
	localparam logic [6:0]  RST_MSG_LENGTH    = 7'd0;

	// first printable character maps to glyph zero
	localparam logic [CHAR_W-1:0] CHAR_BIAS = 8'd32;

endpackage

[design/stfe_ram.sv]
// ----------------------------------------------------------------------------
// stfe_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module stfe_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/scrolling_text_frame_engine.sv]
// ----------------------------------------------------------------------------
// scrolling_text_frame_engine
// Message store, highlight slots and scroll state; renders at most one frame of
// visible glyphs per elapsed tick request.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low.
//   Write, highlight, clear and scroll reset requests finish in that cycle.
//   A tick request that renders no frame also finishes at once.
//   An elapsed tick that renders holds busy high while a sequencer walks
//   the message store one character per cycle (one memory read port);
//   when a smooth scroll step advances, a divide step first recomputes
//   the character position one quotient bit per cycle.
//   Each glyph appears for one cycle with result_strobe high; last_glyph
//   marks the end of the frame, and the scroll fields show the state after
//   the update. The receiver cannot stall the results.
//   Register writes go through cfg_valid/cfg_ready (ready is always high)
//   and must be made only while the block is idle, which it does not enforce.
//   Reset clears the scroll state, the highlight slots and loads the
//   register defaults; the message store holds no reset value.
// ----------------------------------------------------------------------------
module scrolling_text_frame_engine #(
	parameter int MSG_DEPTH         = stfe_pkg::MSG_DEPTH_DEF,
	parameter int HIGHLIGHT_SLOTS   = stfe_pkg::HL_SLOTS_DEF,
	parameter int MAX_DISPLAY_CHARS = stfe_pkg::MAX_DISP_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              start,
	output logic                              busy,
	input  logic [stfe_pkg::REQ_W-1:0]        req_type,
	input  logic [stfe_pkg::TIME_W-1:0]       now_ms,
	input  logic [stfe_pkg::IDX_W-1:0]        msg_index,
	input  logic [stfe_pkg::CHAR_W-1:0]       char_code,
	input  logic [stfe_pkg::IDX_W-1:0]        hl_start,
	input  logic [stfe_pkg::IDX_W-1:0]        hl_end,
	input  logic [stfe_pkg::LEVEL_W-1:0]      hl_brightness,
	// configuration channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [stfe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [stfe_pkg::CFG_DATA_W-1:0]   cfg_data,
	// result channel
	output logic                              result_strobe,
	output logic [stfe_pkg::CHAR_W-1:0]       glyph_code,
	output logic signed [stfe_pkg::POS_W-1:0] glyph_x,
	output logic [stfe_pkg::LEVEL_W-1:0]      brightness,
	output logic                              glyph_font_modern,
	output logic                              last_glyph,
	output logic                              scroll_done,
	output logic [stfe_pkg::SCROLL_W-1:0]     char_position_out,
	output logic [stfe_pkg::SCROLL_W-1:0]     pixel_offset_out
);

	import stfe_pkg::*;

	localparam int AW    = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
	localparam int CNTW  = $clog2(MSG_DEPTH + 1);
	localparam int DW    = $clog2(MAX_DISPLAY_CHARS + 1);
	localparam int DPXW  = DW + 4;
	localparam int SW    = CNTW + 1;
	localparam int TW    = SW + 5;
	localparam int PW    = (CNTW + 6 > 12) ? CNTW + 6 : 12;
	localparam int DIV_LAST = SCROLL_W - 1;
	localparam int DCW   = $clog2(SCROLL_W);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SCAN, ST_FLUSH} state_t;

	state_t state_q;

	// configuration registers
	logic [4:0]  disp_q;
	logic [3:0]  cwid_q;
	logic [2:0]  spc_q;
	logic [1:0]  style_q;
	logic [15:0] period_q;
	logic [7:0]  dflt_q;
	logic        font_q;
	logic [6:0]  mlen_q;

	// scroll state
	logic [SCROLL_W-1:0] sp_q;
	logic [SCROLL_W-1:0] sc_q;
	logic                done_q;
	logic [TIME_W-1:0]   last_q;

	// highlight slots
	logic [HIGHLIGHT_SLOTS-1:0] hl_act_q;
	logic [IDX_W-1:0]           hl_first_q [HIGHLIGHT_SLOTS];
	logic [IDX_W-1:0]           hl_last_q  [HIGHLIGHT_SLOTS];
	logic [LEVEL_W-1:0]         hl_level_q [HIGHLIGHT_SLOTS];
	logic [HIGHLIGHT_SLOTS-1:0] hl_sel;

	// sequencer and divider
	logic [CNTW-1:0]      rd_idx_q;
	logic signed [PW-1:0] pos_q;
	logic [SCROLL_W-1:0]  quot_q;
	logic [3:0]           rem_q;
	logic [DCW-1:0]       div_cnt_q;
	logic [4:0]           div_pre;
	logic                 div_ge;
	logic [3:0]           rem_nxt;

	// scan pipeline, aligned with the memory read data
	logic                 v_s1;
	logic [CNTW-1:0]      idx_s1;
	logic signed [PW-1:0] pos_s1;
	logic                 vis_s1;

	// held glyph, so that the final one of a frame can be marked
	logic               pend_v_q;
	logic [CHAR_W-1:0]  pend_code_q;
	logic [POS_W-1:0]   pend_pos_q;
	logic [LEVEL_W-1:0] pend_lvl_q;

	// result registers
	logic               strobe_q;
	logic [CHAR_W-1:0]  code_q;
	logic [POS_W-1:0]   opos_q;
	logic [LEVEL_W-1:0] olvl_q;
	logic               olast_q;

	// derived sizes
	logic [3:0]           cw;
	logic [DW-1:0]        dsz;
	logic [CNTW-1:0]      len;
	logic [4:0]           ew;
	logic [DPXW-1:0]      dpx;
	logic [SW-1:0]        span;
	logic [TW-1:0]        total_s;
	logic [SCROLL_W-1:0]  sp_inc;
	logic [SCROLL_W-1:0]  sc_inc;
	logic [13:0]          char_prod;
	logic signed [PW-1:0] neg_sp;
	logic signed [PW-1:0] neg_cw;
	logic signed [PW-1:0] dpx_s;
	logic                 vis_now;
	logic                 short_msg;
	logic                 accept;
	logic                 tick_ok;
	logic                 mem_we;
	logic [CHAR_W-1:0]    mem_rdata;
	logic [LEVEL_W-1:0]   g_lvl;
	logic                 g_hit;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// effective sizes from the registers
	assign cw  = (cwid_q == 4'd0) ? 4'd1 : cwid_q;
	assign dsz = (32'(disp_q) > MAX_DISPLAY_CHARS) ? DW'(MAX_DISPLAY_CHARS) : DW'(disp_q);
	assign len = (32'(mlen_q) > MSG_DEPTH) ? CNTW'(MSG_DEPTH) : CNTW'(mlen_q);
	assign ew  = (style_q == STYLE_SMOOTH) ? 5'(cw) + 5'(spc_q) : 5'(cw);
	assign dpx = DPXW'(dsz) * DPXW'(cw);
	assign short_msg = (32'(len) <= 32'(dsz));

	// scroll limits and next positions
	assign span      = SW'(len) - SW'(dsz) + SW'(1);
	assign total_s   = TW'(span) * TW'(ew);
	assign sp_inc    = sp_q + SCROLL_W'(1);
	assign sc_inc    = sc_q + SCROLL_W'(1);
	assign char_prod = 14'(sc_inc) * 14'(cw);
	assign neg_sp    = PW'(0) - PW'(sp_q);
	assign neg_cw    = PW'(0) - PW'(cw);
	assign dpx_s     = PW'(dpx);
	assign vis_now   = (pos_q > neg_cw) && (pos_q < dpx_s);

	// tick qualification
	assign tick_ok = accept && (req_type == REQ_TICK) && (len != '0)
		&& ((now_ms - last_q) >= TIME_W'(period_q));

	// restoring divide step
	assign div_pre = {rem_q, quot_q[SCROLL_W-1]};
	assign div_ge  = (div_pre >= {1'b0, cw});
	assign rem_nxt = div_ge ? 4'(div_pre - {1'b0, cw}) : div_pre[3:0];

	// first free highlight slot
	always_comb begin
		logic taken;
		taken  = 1'b0;
		hl_sel = '0;
		for (int s = 0; s < HIGHLIGHT_SLOTS; s++) begin
			if (!hl_act_q[s] && !taken) begin
				hl_sel[s] = 1'b1;
			end
			taken = taken | !hl_act_q[s];
		end
	end

	// brightness: lowest matching active slot wins
	always_comb begin
		g_lvl = dflt_q;
		for (int s = HIGHLIGHT_SLOTS - 1; s >= 0; s--) begin
			if (hl_act_q[s] && (32'(idx_s1) >= 32'(hl_first_q[s]))
				&& (32'(idx_s1) <= 32'(hl_last_q[s]))) begin
				g_lvl = hl_level_q[s];
			end
		end
	end

	assign g_hit = v_s1 && vis_s1;

	// message store
	assign mem_we = accept && (req_type == REQ_WRITE) && (32'(msg_index) < MSG_DEPTH);

	stfe_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (MSG_DEPTH)
	) u_msg_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (AW'(msg_index)),
		.wdata (char_code),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (mem_rdata)
	);

	// highlight slot payload
	always_ff @(posedge clk) begin
		if (accept && (req_type == REQ_HL_ADD)) begin
			for (int s = 0; s < HIGHLIGHT_SLOTS; s++) begin
				if (hl_sel[s]) begin
					hl_first_q[s] <= hl_start;
					hl_last_q[s]  <= hl_end;
					hl_level_q[s] <= hl_brightness;
				end
			end
		end
	end

	// sequencer, state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			disp_q    <= RST_DISPLAY_CHARS;
			cwid_q    <= RST_CHAR_WIDTH;
			spc_q     <= RST_CHAR_SPACING;
			style_q   <= RST_SCROLL_STYLE;
			period_q  <= RST_PERIOD_MS;
			dflt_q    <= RST_DEFAULT_LEVEL;
			font_q    <= RST_FONT_MODERN;
			mlen_q    <= RST_MSG_LENGTH;
			sp_q      <= '0;
			sc_q      <= '0;
			done_q    <= 1'b0;
			last_q    <= '0;
			hl_act_q  <= '0;
			rd_idx_q  <= '0;
			pos_q     <= '0;
			quot_q    <= '0;
			rem_q     <= '0;
			div_cnt_q <= '0;
			v_s1      <= 1'b0;
			idx_s1    <= '0;
			pos_s1    <= '0;
			vis_s1    <= 1'b0;
			pend_v_q  <= 1'b0;
			strobe_q  <= 1'b0;
			olast_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			olast_q  <= 1'b0;
			v_s1     <= 1'b0;

			// register writes
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_DISPLAY_CHARS: disp_q   <= cfg_data[4:0];
					CFG_CHAR_WIDTH:    cwid_q   <= cfg_data[3:0];
					CFG_CHAR_SPACING:  spc_q    <= cfg_data[2:0];
					CFG_SCROLL_STYLE:  style_q  <= cfg_data[1:0];
					CFG_PERIOD_MS:     period_q <= cfg_data[15:0];
					CFG_DEFAULT_LEVEL: dflt_q   <= cfg_data[7:0];
					CFG_FONT_MODERN:   font_q   <= cfg_data[0];
					CFG_MSG_LENGTH:    mlen_q   <= cfg_data[6:0];
				endcase
			end

			// glyph from the scan pipeline: release the held one, hold the new one
			if (g_hit) begin
				if (pend_v_q) begin
					strobe_q <= 1'b1;
					code_q   <= pend_code_q;
					opos_q   <= pend_pos_q;
					olvl_q   <= pend_lvl_q;
				end
				pend_v_q    <= 1'b1;
				pend_code_q <= mem_rdata - CHAR_BIAS;
				pend_pos_q  <= pos_s1[POS_W-1:0];
				pend_lvl_q  <= g_lvl;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req_type)
							REQ_HL_ADD: hl_act_q <= hl_act_q | hl_sel;
							REQ_HL_CLR: hl_act_q <= '0;
							REQ_SCROLL_RST: begin
								sp_q   <= '0;
								sc_q   <= '0;
								done_q <= 1'b0;
								last_q <= '0;
							end
							default: begin
							end
						endcase
					end
					if (tick_ok) begin
						last_q   <= now_ms;
						rd_idx_q <= '0;
						unique case (style_q)
							STYLE_STATIC: begin
								done_q  <= 1'b1;
								pos_q   <= '0;
								state_q <= ST_SCAN;
							end
							STYLE_SMOOTH: begin
								if (short_msg) begin
									done_q  <= 1'b1;
									pos_q   <= neg_sp;
									state_q <= ST_SCAN;
								end else if (32'(sp_q) >= 32'(total_s)) begin
									done_q <= 1'b1;
								end else begin
									pos_q     <= neg_sp;
									sp_q      <= sp_inc;
									quot_q    <= sp_inc;
									rem_q     <= '0;
									div_cnt_q <= '0;
									state_q   <= ST_DIV;
								end
							end
							STYLE_CHAR: begin
								if (short_msg) begin
									done_q  <= 1'b1;
									pos_q   <= neg_sp;
									state_q <= ST_SCAN;
								end else if (32'(sc_q) >= 32'(span)) begin
									done_q <= 1'b1;
								end else begin
									pos_q   <= neg_sp;
									sc_q    <= sc_inc;
									sp_q    <= char_prod[SCROLL_W-1:0];
									state_q <= ST_SCAN;
								end
							end
							// unused style only consumes the period
							default: begin
							end
						endcase
					end
				end

				// character position = pixel offset / char width, one bit a cycle
				ST_DIV: begin
					quot_q <= {quot_q[SCROLL_W-2:0], div_ge};
					rem_q  <= rem_nxt;
					if (div_cnt_q == DCW'(DIV_LAST)) begin
						sc_q    <= {quot_q[SCROLL_W-2:0], div_ge};
						state_q <= ST_SCAN;
					end else begin
						div_cnt_q <= div_cnt_q + DCW'(1);
					end
				end

				// one message read per cycle with the visibility compare
				ST_SCAN: begin
					if (32'(rd_idx_q) < 32'(len)) begin
						v_s1     <= 1'b1;
						idx_s1   <= rd_idx_q;
						pos_s1   <= pos_q;
						vis_s1   <= vis_now;
						pos_q    <= pos_q + PW'(ew);
						rd_idx_q <= rd_idx_q + CNTW'(1);
					end else begin
						state_q <= ST_FLUSH;
					end
				end

				// release the held glyph as the last of the frame
				ST_FLUSH: begin
					if (!v_s1) begin
						if (pend_v_q) begin
							strobe_q <= 1'b1;
							olast_q  <= 1'b1;
							code_q   <= pend_code_q;
							opos_q   <= pend_pos_q;
							olvl_q   <= pend_lvl_q;
							pend_v_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result ports
	assign result_strobe     = strobe_q;
	assign glyph_code        = code_q;
	assign glyph_x           = opos_q;
	assign brightness        = olvl_q;
	assign glyph_font_modern = font_q;
	assign last_glyph        = olast_q;
	assign scroll_done       = done_q;
	assign char_position_out = sc_q;
	assign pixel_offset_out  = sp_q;

endmodule

[design/stfe_checker.sv]
// ----------------------------------------------------------------------------
// stfe_checker
// Port level checks on frame sequencing of the scrolling text frame engine.
// ----------------------------------------------------------------------------
module stfe_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              busy,
	input logic                              result_strobe,
	input logic                              last_glyph,
	input logic                              scroll_done,
	input logic [stfe_pkg::SCROLL_W-1:0]     char_position_out,
	input logic [stfe_pkg::SCROLL_W-1:0]     pixel_offset_out
);

	import stfe_pkg::*;

	// a glyph that does not end the frame leaves the engine busy
	a_mid_frame_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_glyph |-> busy)
		else $error("glyph inside a frame while not busy");

	// the end marker only comes with a glyph
	a_last_with_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_glyph |-> result_strobe)
		else $error("last glyph flag without a glyph");

	// a frame ends cleanly: nothing follows its last glyph at once
	a_gap_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last_glyph |=> !result_strobe)
		else $error("glyph right after the end of a frame");

	// no glyph in the cycle a frame starts
	a_no_glyph_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> !result_strobe)
		else $error("glyph when the frame request was just taken");

	// scroll state is the same over all glyphs of a frame
	a_scroll_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_glyph |=> $stable(char_position_out)
			&& $stable(pixel_offset_out) && $stable(scroll_done))
		else $error("scroll state changed inside a frame");

endmodule

bind scrolling_text_frame_engine stfe_checker u_stfe_checker (.*);

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrolling text frame engine testbench
// Drives requests and register writes, predicts every rendered glyph from
// an internal copy of the message, highlight and scroll state, and checks
// each strobed glyph field by field in order of arrival.
// ----------------------------------------------------------------------------
import stfe_pkg::*;

typedef struct packed {
	logic [REQ_W-1:0]   kind;
	logic [TIME_W-1:0]  now;
	logic [IDX_W-1:0]   index;
	logic [CHAR_W-1:0]  code;
	logic [IDX_W-1:0]   first;
	logic [IDX_W-1:0]   last;
	logic [LEVEL_W-1:0] level;
} request_t;

typedef struct packed {
	logic [CHAR_W-1:0]   code;
	logic [POS_W-1:0]    pos;
	logic [LEVEL_W-1:0]  level;
	logic                font;
	logic                last;
	logic                done;
	logic [SCROLL_W-1:0] chars;
	logic [SCROLL_W-1:0] pixels;
} glyph_t;

// frame predictor and in-order glyph checker
class frame_scoreboard;
	int disp_chars, char_px, spacing_px, style, period, def_level, font, msg_len;
	logic [CHAR_W-1:0] message [MSG_DEPTH_DEF];
	bit hl_on [HL_SLOTS_DEF];
	int hl_first [HL_SLOTS_DEF];
	int hl_last [HL_SLOTS_DEF];
	int hl_level [HL_SLOTS_DEF];
	int scroll_px, scroll_ch;
	bit done;
	logic [TIME_W-1:0] last_update;
	glyph_t frame_buf[$];
	glyph_t expected_glyphs[$];
	int mismatches;

	function new();
		disp_chars = RST_DISPLAY_CHARS;
		char_px = RST_CHAR_WIDTH;
		spacing_px = RST_CHAR_SPACING;
		style = RST_SCROLL_STYLE;
		period = RST_PERIOD_MS;
		def_level = RST_DEFAULT_LEVEL;
		font = RST_FONT_MODERN;
		msg_len = RST_MSG_LENGTH;
		foreach (hl_on[s]) hl_on[s] = 0;
		scroll_px = 0;
		scroll_ch = 0;
		done = 0;
		last_update = '0;
		mismatches = 0;
	endfunction

	function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_DISPLAY_CHARS: disp_chars = data[4:0];
			CFG_CHAR_WIDTH:    char_px = data[3:0];
			CFG_CHAR_SPACING:  spacing_px = data[2:0];
			CFG_SCROLL_STYLE:  style = data[1:0];
			CFG_PERIOD_MS:     period = data[15:0];
			CFG_DEFAULT_LEVEL: def_level = data[7:0];
			CFG_FONT_MODERN:   font = data[0];
			CFG_MSG_LENGTH:    msg_len = data[6:0];
			default: ;
		endcase
	endfunction

	// one visible glyph, brightness from the lowest matching highlight slot
	function void emit_glyph(int idx, int pos);
		glyph_t g;
		int lvl;
		lvl = def_level;
		for (int s = HL_SLOTS_DEF - 1; s >= 0; s--)
			if (hl_on[s] && idx >= hl_first[s] && idx <= hl_last[s])
				lvl = hl_level[s];
		g = '0;
		g.code = message[idx] - CHAR_BIAS;
		g.pos = pos[POS_W-1:0];
		g.level = lvl[7:0];
		g.font = font[0];
		frame_buf.push_back(g);
	endfunction

	function void build_frame(int len, int d, int cw);
		int ew, dpx, pos, m;
		if (style == STYLE_STATIC) begin
			m = (len < d) ? len : d;
			for (int i = 0; i < m; i++)
				emit_glyph(i, i * cw);
		end else begin
			ew = (style == STYLE_SMOOTH) ? cw + spacing_px : cw;
			dpx = d * cw;
			for (int i = 0; i < len; i++) begin
				pos = i * ew - scroll_px;
				if (pos > -cw && pos < dpx)
					emit_glyph(i, pos);
			end
		end
	endfunction

	// tick: period check, frame and scroll advance
	function void advance_on_tick(logic [TIME_W-1:0] now);
		int len, d, cw, total;
		logic [TIME_W-1:0] elapsed;
		len = (msg_len > MSG_DEPTH_DEF) ? MSG_DEPTH_DEF : msg_len;
		d = (disp_chars > MAX_DISP_DEF) ? MAX_DISP_DEF : disp_chars;
		cw = (char_px == 0) ? 1 : char_px;
		frame_buf.delete();
		if (len == 0)
			return;
		elapsed = now - last_update;
		if (elapsed < period)
			return;
		last_update = now;
		if (style == STYLE_STATIC) begin
			build_frame(len, d, cw);
			done = 1;
		end else if (style == STYLE_SMOOTH || style == STYLE_CHAR) begin
			if (len <= d) begin
				build_frame(len, d, cw);
				done = 1;
			end else if (style == STYLE_SMOOTH) begin
				total = (len - d + 1) * (cw + spacing_px);
				if (scroll_px >= total) begin
					done = 1;
				end else begin
					build_frame(len, d, cw);
					scroll_px = (scroll_px + 1) & 10'h3FF;
					scroll_ch = (scroll_px / cw) & 10'h3FF;
				end
			end else begin
				total = len - d + 1;
				if (scroll_ch >= total) begin
					done = 1;
				end else begin
					build_frame(len, d, cw);
					scroll_ch = (scroll_ch + 1) & 10'h3FF;
					scroll_px = (scroll_ch * cw) & 10'h3FF;
				end
			end
		end
		foreach (frame_buf[k]) begin
			frame_buf[k].last = (k == frame_buf.size() - 1);
			frame_buf[k].done = done;
			frame_buf[k].chars = scroll_ch[SCROLL_W-1:0];
			frame_buf[k].pixels = scroll_px[SCROLL_W-1:0];
			expected_glyphs.push_back(frame_buf[k]);
		end
	endfunction

	function void note_request(request_t rq);
		bit placed;
		placed = 0;
		case (rq.kind)
			REQ_TICK: advance_on_tick(rq.now);
			REQ_WRITE: message[rq.index] = rq.code;
			REQ_HL_ADD: begin
				for (int s = 0; s < HL_SLOTS_DEF; s++)
					if (!placed && !hl_on[s]) begin
						hl_first[s] = rq.first;
						hl_last[s] = rq.last;
						hl_level[s] = rq.level;
						hl_on[s] = 1;
						placed = 1;
					end
			end
			REQ_HL_CLR: foreach (hl_on[s]) hl_on[s] = 0;
			REQ_SCROLL_RST: begin
				scroll_px = 0;
				scroll_ch = 0;
				done = 0;
				last_update = '0;
			end
			default: ;
		endcase
	endfunction

	function void check_glyph(glyph_t got);
		glyph_t want;
		if (expected_glyphs.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected glyph: code %0d pos %0d", got.code, $signed(got.pos));
			return;
		end
		want = expected_glyphs.pop_front();
		if (got.code != want.code || got.pos != want.pos || got.level != want.level ||
				got.font != want.font || got.last != want.last || got.done != want.done ||
				got.chars != want.chars || got.pixels != want.pixels) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("glyph mismatch expected: code %0d pos %0d level %0d font %0d",
					want.code, $signed(want.pos), want.level, want.font,
					" last %0d done %0d chars %0d pixels %0d",
					want.last, want.done, want.chars, want.pixels);
				$display("glyph mismatch actual:   code %0d pos %0d level %0d font %0d",
					got.code, $signed(got.pos), got.level, got.font,
					" last %0d done %0d chars %0d pixels %0d",
					got.last, got.done, got.chars, got.pixels);
			end
		end
	endfunction
endclass

module testbench;

	localparam int SETTLE_CYCLES  = 100;
	localparam int WATCHDOG_LIMIT = 4000;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic [REQ_W-1:0]        req_type = '0;
	logic [TIME_W-1:0]       now_ms = '0;
	logic [IDX_W-1:0]        msg_index = '0;
	logic [CHAR_W-1:0]       char_code = '0;
	logic [IDX_W-1:0]        hl_start = '0;
	logic [IDX_W-1:0]        hl_end = '0;
	logic [LEVEL_W-1:0]      hl_brightness = '0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    result_strobe;
	logic [CHAR_W-1:0]       glyph_code;
	logic signed [POS_W-1:0] glyph_x;
	logic [LEVEL_W-1:0]      brightness;
	logic                    glyph_font_modern;
	logic                    last_glyph;
	logic                    scroll_done;
	logic [SCROLL_W-1:0]     char_position_out;
	logic [SCROLL_W-1:0]     pixel_offset_out;

	frame_scoreboard sb = new();
	int requests_taken = 0;
	int cfg_writes = 0;
	int quiet_cycles = 0;

	scrolling_text_frame_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.now_ms(now_ms),
		.msg_index(msg_index),
		.char_code(char_code),
		.hl_start(hl_start),
		.hl_end(hl_end),
		.hl_brightness(hl_brightness),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_strobe(result_strobe),
		.glyph_code(glyph_code),
		.glyph_x(glyph_x),
		.brightness(brightness),
		.glyph_font_modern(glyph_font_modern),
		.last_glyph(last_glyph),
		.scroll_done(scroll_done),
		.char_position_out(char_position_out),
		.pixel_offset_out(pixel_offset_out)
	);

	always #5 clk = ~clk;

	// sample handshakes and glyphs on the rising edge, plus the watchdog
	always @(posedge clk) begin : sample_ports
		glyph_t seen;
		request_t rq;
		bit moved;
		moved = 0;
		if (arst_n) begin
			if (result_strobe) begin
				seen.code = glyph_code;
				seen.pos = glyph_x;
				seen.level = brightness;
				seen.font = glyph_font_modern;
				seen.last = last_glyph;
				seen.done = scroll_done;
				seen.chars = char_position_out;
				seen.pixels = pixel_offset_out;
				sb.check_glyph(seen);
				moved = 1;
			end
			if (cfg_valid && cfg_ready) begin
				sb.apply_register(cfg_index, cfg_data);
				cfg_writes++;
				moved = 1;
			end
			if (start && !busy) begin
				rq.kind = req_type;
				rq.now = now_ms;
				rq.index = msg_index;
				rq.code = char_code;
				rq.first = hl_start;
				rq.last = hl_end;
				rq.level = hl_brightness;
				sb.note_request(rq);
				requests_taken++;
				moved = 1;
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic request_t mk(logic [REQ_W-1:0] kind, logic [TIME_W-1:0] now,
			int index, int code, int first, int last, int level);
		request_t rq;
		rq.kind = kind;
		rq.now = now;
		rq.index = index[IDX_W-1:0];
		rq.code = code[CHAR_W-1:0];
		rq.first = first[IDX_W-1:0];
		rq.last = last[IDX_W-1:0];
		rq.level = level[LEVEL_W-1:0];
		return rq;
	endfunction

	// mostly elapsed ticks so scrolling gets deep, with edits and noise
	function automatic request_t random_request();
		request_t rq;
		int pick, mode;
		rq = mk(REQ_TICK, $urandom, $urandom_range(0, 63), $urandom_range(0, 255),
			$urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			mode = $urandom_range(0, 99);
			if (mode < 75)
				rq.now = sb.last_update + sb.period + $urandom_range(0, 3);
			else if (mode < 87)
				rq.now = sb.last_update + $urandom_range(0, sb.period);
		end else if (pick < 70)
			rq.kind = REQ_WRITE;
		else if (pick < 82)
			rq.kind = REQ_HL_ADD;
		else if (pick < 87)
			rq.kind = REQ_HL_CLR;
		else if (pick < 92)
			rq.kind = REQ_SCROLL_RST;
		else
			rq.kind = REQ_W'($urandom_range(REQ_SCROLL_RST + 1, 7));
		return rq;
	endfunction

	// called at a falling edge; leaves start high after the request is taken
	task automatic send_request(request_t rq);
		int taken;
		req_type = rq.kind;
		now_ms = rq.now;
		msg_index = rq.index;
		char_code = rq.code;
		hl_start = rq.first;
		hl_end = rq.last;
		hl_brightness = rq.level;
		start = 1'b1;
		taken = requests_taken;
		do @(negedge clk); while (requests_taken == taken);
	endtask

	task automatic idle_sender(int cycles);
		start = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic drain();
		start = 1'b0;
		while (sb.expected_glyphs.size() != 0) @(negedge clk);
	endtask

	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, int value);
		int taken;
		cfg_index = idx;
		cfg_data = value[CFG_DATA_W-1:0];
		cfg_valid = 1'b1;
		taken = cfg_writes;
		do @(negedge clk); while (cfg_writes == taken);
		cfg_valid = 1'b0;
	endtask

	// one register setting followed by random requests
	task automatic run_phase(int disp, int cw, int sp, int style, int period, int level,
			int font, int len, int count, bit gaps, bit hold_midway);
		request_t rq;
		int sent;
		settle();
		write_register(CFG_DISPLAY_CHARS, disp);
		write_register(CFG_CHAR_WIDTH, cw);
		write_register(CFG_CHAR_SPACING, sp);
		write_register(CFG_SCROLL_STYLE, style);
		write_register(CFG_PERIOD_MS, period);
		write_register(CFG_DEFAULT_LEVEL, level);
		write_register(CFG_FONT_MODERN, font);
		write_register(CFG_MSG_LENGTH, len);
		send_request(mk(REQ_SCROLL_RST, 0, 0, 0, 0, 0, 0));
		sent = 0;
		while (sent < count) begin
			if (gaps && $urandom_range(0, 3) == 0)
				idle_sender($urandom_range(1, 17));
			if (hold_midway && sent == count / 2) begin
				drain();
				hold_midway = 0;
			end
			rq = random_request();
			send_request(rq);
			if (rq.kind <= REQ_SCROLL_RST)
				sent++;
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// fill the whole message store so no unwritten entry is ever read
		for (int i = 0; i < MSG_DEPTH_DEF; i++)
			send_request(mk(REQ_WRITE, 0, i, (i == 0) ? 0 : (i == 1) ? 255 :
				(i == 2) ? 32 : (i == 3) ? 31 : $urandom_range(0, 255), 0, 0, 0));

		// empty message: tick does nothing
		send_request(mk(REQ_TICK, 1000, 0, 0, 0, 0, 0));
		settle();
		write_register(CFG_MSG_LENGTH, 12);

		// highlights: overlap, empty range, open end, one too many
		send_request(mk(REQ_HL_ADD, 0, 0, 0, 0, 3, 255));
		send_request(mk(REQ_HL_ADD, 0, 0, 0, 2, 5, 0));
		send_request(mk(REQ_HL_ADD, 0, 0, 0, 63, 0, 128));
		send_request(mk(REQ_HL_ADD, 0, 0, 0, 6, 63, 77));
		send_request(mk(REQ_HL_ADD, 0, 0, 0, 1, 1, 9));

		// period boundaries and time wrap
		send_request(mk(REQ_TICK, 0, 0, 0, 0, 0, 0));
		send_request(mk(REQ_TICK, 50, 0, 0, 0, 0, 0));
		send_request(mk(REQ_TICK, 99, 0, 0, 0, 0, 0));
		send_request(mk(REQ_TICK, 100, 0, 0, 0, 0, 0));
		send_request(mk(REQ_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
		send_request(mk(REQ_TICK, 32'h0000_0010, 0, 0, 0, 0, 0));
		send_request(mk(REQ_TICK, 32'h0000_0031, 0, 0, 0, 0, 0));

		// clear, unknown codes, edit outside the view, scroll reset
		send_request(mk(REQ_HL_CLR, 0, 0, 0, 0, 0, 0));
		for (int k = REQ_SCROLL_RST + 1; k <= 7; k++)
			send_request(mk(REQ_W'(k), $urandom, $urandom_range(0, 63),
				$urandom_range(0, 255), $urandom_range(0, 63), $urandom_range(0, 63),
				$urandom_range(0, 255)));
		send_request(mk(REQ_WRITE, 0, 63, 255, 0, 0, 0));
		send_request(mk(REQ_SCROLL_RST, 0, 0, 0, 0, 0, 0));
		send_request(mk(REQ_TICK, 50, 0, 0, 0, 0, 0));
		send_request(mk(REQ_TICK, 100, 0, 0, 0, 0, 0));

		// random phases across register settings
		run_phase(8, 2, 7, STYLE_SMOOTH, 0, 0, 0, 10, 8, 1, 1);
		run_phase(16, 8, 0, STYLE_CHAR, 65535, 255, 1, 64, 8, 1, 0);
		run_phase(31, 0, 3, STYLE_STATIC, 7, 200, 1, 127, 8, 1, 0);
		run_phase(2, 1, 0, STYLE_SMOOTH, 3, 17, 0, 6, 9, 1, 0);
		run_phase(8, 5, 1, 3, 10, 1, 1, 20, 5, 1, 0);
		run_phase(8, 5, 1, STYLE_SMOOTH, 50, 64, 0, 3, 7, 1, 0);
		run_phase(8, 6, 2, STYLE_CHAR, 1, 128, 1, 10, 8, 1, 0);
		run_phase(1, 8, 7, STYLE_SMOOTH, 0, 99, 1, 64, 14, 0, 0);

		settle();
		if (sb.mismatches == 0 && sb.expected_glyphs.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
design/stfe_pkg.sv
design/stfe_ram.sv
design/scrolling_text_frame_engine.sv
design/stfe_checker.sv
bench/testbench.sv
